// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the console engine modules.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/tccs_pkg.sv
// Package for the text console engine: field widths, character codes,
// microcode control word, step encoding and the microprogram ROM. No dependencies.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int INDEX_W   = 11;
    localparam int OCOL_W    = 7;
    localparam int OROW_W    = 5;
    localparam int LOC_W     = 11;
    localparam int DATA_W    = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0720;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_RESET   = 4'd0,
        ST_RFILL   = 4'd1,
        ST_IDLE    = 4'd2,
        ST_PUT     = 4'd3,
        ST_COPY_RD = 4'd4,
        ST_COPY_WR = 4'd5,
        ST_FILL    = 4'd6,
        ST_DONE    = 4'd7,
        ST_CLEAR   = 4'd8,
        ST_READ    = 4'd9
    } t_step;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_HOME
    } t_cur_op;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_INC
    } t_addr_op;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_FILL,
        MEM_COPY_RD,
        MEM_COPY_WR,
        MEM_READ
    } t_mem_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_SCROLL,
        COND_FILL_MORE,
        COND_COPY_MORE,
        COND_OUT_BLOCKED
    } t_cond;

    typedef struct packed {
        logic     in_ready;
        logic     dispatch;
        logic     out_load;
        t_cur_op  cur_op;
        t_addr_op addr_op;
        t_mem_op  mem_op;
        t_cond    hold;
        t_cond    jump;
        t_step    target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        t_op  in_op;
        logic scroll;
        logic fill_more;
        logic copy_more;
        logic out_blocked;
    } t_stat;

    // The microprogram. Priority in the sequencer: hold, dispatch, jump, next step.
    function automatic t_ctrl ucode(t_step s);
        t_ctrl c;
        c = '{in_ready: 1'b0, dispatch: 1'b0, out_load: 1'b0, cur_op: CUR_HOLD,
              addr_op: ADDR_HOLD, mem_op: MEM_NONE, hold: COND_NEVER,
              jump: COND_NEVER, target: ST_IDLE};
        case (s)
            ST_RESET: begin
                c.addr_op = ADDR_ZERO;
            end
            ST_RFILL: begin
                c.mem_op  = MEM_FILL;
                c.addr_op = ADDR_INC;
                c.jump    = COND_FILL_MORE;
                c.target  = ST_RFILL;
            end
            ST_IDLE: begin
                c.in_ready = 1'b1;
                c.hold     = COND_NO_INPUT;
                c.dispatch = 1'b1;
            end
            ST_PUT: begin
                c.mem_op  = MEM_PUT;
                c.cur_op  = CUR_ADVANCE;
                c.addr_op = ADDR_ZERO;
                c.jump    = COND_NO_SCROLL;
                c.target  = ST_DONE;
            end
            ST_COPY_RD: begin
                c.mem_op = MEM_COPY_RD;
            end
            ST_COPY_WR: begin
                c.mem_op  = MEM_COPY_WR;
                c.addr_op = ADDR_INC;
                c.jump    = COND_COPY_MORE;
                c.target  = ST_COPY_RD;
            end
            ST_FILL: begin
                c.mem_op  = MEM_FILL;
                c.addr_op = ADDR_INC;
                c.jump    = COND_FILL_MORE;
                c.target  = ST_FILL;
            end
            ST_DONE: begin
                c.out_load = 1'b1;
                c.hold     = COND_OUT_BLOCKED;
                c.jump     = COND_ALWAYS;
                c.target   = ST_IDLE;
            end
            ST_CLEAR: begin
                c.cur_op  = CUR_HOME;
                c.addr_op = ADDR_ZERO;
                c.jump    = COND_ALWAYS;
                c.target  = ST_FILL;
            end
            ST_READ: begin
                c.mem_op = MEM_READ;
                c.jump   = COND_ALWAYS;
                c.target = ST_DONE;
            end
            default: begin
                c.jump   = COND_ALWAYS;
                c.target = ST_RESET;
            end
        endcase
        return c;
    endfunction

    function automatic t_step dispatch_target(t_op op);
        t_step s;
        case (op)
            OP_PUT:   s = ST_PUT;
            OP_CLEAR: s = ST_CLEAR;
            OP_READ:  s = ST_READ;
            default:  s = ST_DONE;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/tccs_useq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on tccs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tccs_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tccs_pkg::t_stat i_stat,
    output tccs_pkg::t_ctrl o_ctrl
);

    tccs_pkg::t_step r_step;
    tccs_pkg::t_step n_step;
    tccs_pkg::t_ctrl cw;
    logic            hold_true;
    logic            jump_true;

    function automatic logic cond_true(tccs_pkg::t_cond c, tccs_pkg::t_stat s);
        logic v;
        case (c)
            tccs_pkg::COND_ALWAYS:      v = 1'b1;
            tccs_pkg::COND_NO_INPUT:    v = !s.in_valid;
            tccs_pkg::COND_NO_SCROLL:   v = !s.scroll;
            tccs_pkg::COND_FILL_MORE:   v = s.fill_more;
            tccs_pkg::COND_COPY_MORE:   v = s.copy_more;
            tccs_pkg::COND_OUT_BLOCKED: v = s.out_blocked;
            default:                    v = 1'b0;
        endcase
        return v;
    endfunction

    assign cw        = tccs_pkg::ucode(r_step);
    assign hold_true = cond_true(cw.hold, i_stat);
    assign jump_true = cond_true(cw.jump, i_stat);

    always_comb begin
        n_step = tccs_pkg::t_step'(r_step + 4'd1);
        if (hold_true) begin
            n_step = r_step;
        end else if (cw.dispatch && i_stat.in_valid) begin
            n_step = tccs_pkg::dispatch_target(i_stat.in_op);
        end else if (jump_true) begin
            n_step = cw.target;
        end
    end

    always_comb begin
        o_ctrl = cw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tccs_pkg::ST_RESET;
        end else begin
            r_step <= n_step;
        end
    end

    `ASSERT_CLKD(a_scroll_runs_copy, (r_step == tccs_pkg::ST_PUT && i_stat.scroll) |=> (r_step == tccs_pkg::ST_COPY_RD), "scroll did not start the row copy")
    `ASSERT_CLKD(a_done_returns_idle, (r_step == tccs_pkg::ST_DONE && !i_stat.out_blocked) |=> (r_step == tccs_pkg::ST_IDLE), "sequencer did not return to idle after result")

endmodule

// File: hw/rtl/tccs_dpath.sv
// Datapath: input capture, cursor registers, cell store with registered read,
// sweep address counter and the output register. Depends on tccs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tccs_dpath #(
    parameter int COLUMNS   = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS      = tccs_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tccs_pkg::DEF_TAB_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tccs_pkg::t_ctrl                   i_ctrl,
    output tccs_pkg::t_stat                   o_stat,
    input  logic                              s_tvalid,
    input  logic [tccs_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tccs_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int TW        = $clog2(TAB_WIDTH);
    localparam int XW        = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int LAST_CELL = CELLS - 1;
    localparam int LAST_COPY = (ROWS - 1) * COLUMNS - 1;

    // Captured command.
    tccs_pkg::t_op                        r_op;
    logic [tccs_pkg::CHAR_W-1:0]          r_char;
    logic [tccs_pkg::COLOR_W-1:0]         r_back;
    logic [tccs_pkg::COLOR_W-1:0]         r_fore;
    logic [tccs_pkg::INDEX_W-1:0]         r_index;
    logic                                 r_in_range;

    // Cursor; r_tab tracks the column modulo the tab width.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [TW-1:0] r_tab;
    logic [AW-1:0] r_addr;

    logic [tccs_pkg::DATA_W-1:0] r_mem [CELLS];
    logic [tccs_pkg::DATA_W-1:0] r_rd;

    logic                           r_m_tvalid;
    logic [tccs_pkg::M_TDATA_W-1:0] r_m_tdata;

    logic                        accept;
    logic                        printable;
    logic [XW-1:0]               adv_col;
    logic [TW-1:0]               adv_tab;
    logic                        row_step;
    logic                        scroll;
    logic [AW-1:0]               cur_loc;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tccs_pkg::DATA_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        out_load;
    logic [tccs_pkg::DATA_W-1:0] cell_data;

    assign accept    = i_ctrl.in_ready & s_tvalid;
    assign printable = (r_char >= tccs_pkg::CH_PRINT_LO) && (r_char <= tccs_pkg::CH_PRINT_HI);
    assign cur_loc   = AW'(int'(r_row) * COLUMNS + int'(r_col));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= tccs_pkg::t_op'(s_tdata[1:0]);
            r_char     <= s_tdata[9:2];
            r_back     <= s_tdata[13:10];
            r_fore     <= s_tdata[17:14];
            r_index    <= s_tdata[28:18];
            r_in_range <= (32'(s_tdata[28:18]) < CELLS);
        end
    end

    // Cursor movement for one put-character command.
    always_comb begin
        adv_col  = XW'(r_col);
        adv_tab  = r_tab;
        row_step = 1'b0;
        case (r_char)
            tccs_pkg::CH_BS: begin
                if (r_col != '0) begin
                    adv_col = XW'(r_col) - XW'(1);
                    adv_tab = (r_tab == '0) ? TW'(TAB_WIDTH - 1) : r_tab - TW'(1);
                end
            end
            tccs_pkg::CH_TAB: begin
                adv_col = XW'(r_col) + XW'(TAB_WIDTH) - XW'(r_tab);
                adv_tab = '0;
            end
            tccs_pkg::CH_CR: begin
                adv_col = '0;
                adv_tab = '0;
            end
            tccs_pkg::CH_LF: begin
                adv_col  = '0;
                adv_tab  = '0;
                row_step = 1'b1;
            end
            default: begin
                if (printable) begin
                    adv_col = XW'(r_col) + XW'(1);
                    adv_tab = (r_tab == TW'(TAB_WIDTH - 1)) ? '0 : r_tab + TW'(1);
                end
            end
        endcase
        if (adv_col >= XW'(COLUMNS)) begin
            adv_col  = '0;
            adv_tab  = '0;
            row_step = 1'b1;
        end
        scroll = row_step && (r_row == RW'(ROWS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_tab <= '0;
        end else begin
            case (i_ctrl.cur_op)
                tccs_pkg::CUR_ADVANCE: begin
                    r_col <= CW'(adv_col);
                    r_tab <= adv_tab;
                    if (row_step && !scroll) begin
                        r_row <= r_row + RW'(1);
                    end
                end
                tccs_pkg::CUR_HOME: begin
                    r_col <= '0;
                    r_row <= '0;
                    r_tab <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            case (i_ctrl.addr_op)
                tccs_pkg::ADDR_ZERO: r_addr <= '0;
                tccs_pkg::ADDR_INC:  r_addr <= r_addr + AW'(1);
                default: begin
                end
            endcase
        end
    end

    // Scroll copies one cell in two steps: read the cell a row below, then write it.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = tccs_pkg::BLANK_CELL;
        rd_en   = 1'b0;
        rd_addr = r_addr + AW'(COLUMNS);
        case (i_ctrl.mem_op)
            tccs_pkg::MEM_PUT: begin
                wr_en   = printable;
                wr_addr = cur_loc;
                wr_data = {r_back, r_fore, r_char};
            end
            tccs_pkg::MEM_FILL: begin
                wr_en = 1'b1;
            end
            tccs_pkg::MEM_COPY_WR: begin
                wr_en   = 1'b1;
                wr_data = r_rd;
            end
            tccs_pkg::MEM_COPY_RD: begin
                rd_en = 1'b1;
            end
            tccs_pkg::MEM_READ: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_index);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign out_load  = i_ctrl.out_load & (!r_m_tvalid | m_tready);
    assign cell_data = (r_op == tccs_pkg::OP_READ && r_in_range) ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {1'b0, cell_data,
                          tccs_pkg::LOC_W'(int'(r_row) * COLUMNS + int'(r_col)),
                          tccs_pkg::OROW_W'(r_row), tccs_pkg::OCOL_W'(r_col)};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    always_comb begin
        o_stat.in_valid    = s_tvalid;
        o_stat.in_op       = tccs_pkg::t_op'(s_tdata[1:0]);
        o_stat.scroll      = scroll;
        o_stat.fill_more   = (r_addr != AW'(LAST_CELL));
        o_stat.copy_more   = (r_addr != AW'(LAST_COPY));
        o_stat.out_blocked = r_m_tvalid & !m_tready;
    end

    `ASSERT_CLKD(a_col_in_range, (32'(r_col) < COLUMNS), "cursor column out of range")
    `ASSERT_CLKD(a_write_in_range, wr_en |-> (32'(wr_addr) < CELLS), "cell store write out of range")
    `ASSERT_CLKD(a_out_from_done, $rose(r_m_tvalid) |-> $past(i_ctrl.out_load), "result raised outside the result step")

endmodule

// File: hw/rtl/text_console_cursor_scroll.sv
// Text console engine: a ROWS x COLUMNS store of 16-bit cells (attribute high,
// character low) with a cursor, run by a small microprogram. Commands arrive as
// one word each and every command returns one word with the cursor position.
// Put character and read cell each run an accept, an execute and a load-result
// step, set by the microprogram; the unused opcode has no execute step. A put
// that passes the last row scrolls: the cell store has one port each way, so
// each cell is copied with a read step and then a write step, and the blank
// row is then filled one cell per cycle. Clear screen fills the store one cell a
// cycle. After reset the engine blanks the store with s_tready low.
// A result waiting on m_tready holds the sequencer in its result step.
// Depends on tccs_pkg, tccs_useq and tccs_dpath.
`timescale 1ns / 1ps

module text_console_cursor_scroll #(
    parameter int COLUMNS   = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS      = tccs_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tccs_pkg::DEF_TAB_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[1:0], character[9:2], bg_colour[13:10], fg_colour[17:14],
    // cell_index[28:18], zero fill [31:29]
    input  logic [tccs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // column[6:0], row[11:7], cursor_location[22:12], cell_data[38:23],
    // zero fill [39]
    output logic [tccs_pkg::M_TDATA_W-1:0] m_tdata
);

    tccs_pkg::t_ctrl ctrl;
    tccs_pkg::t_stat stat;

    tccs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    tccs_dpath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = ctrl.in_ready;

endmodule

// File: sim/text_console_cursor_scroll_chk.sv
// Result checker for the text console engine: keeps its own copy of the cell store
// and cursor, predicts one cursor report per accepted command and compares each word.
// Depends on tccs_pkg.
`timescale 1ns / 1ps

module text_console_cursor_scroll_chk #(
    parameter int COLUMNS   = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS      = tccs_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tccs_pkg::DEF_TAB_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // op[1:0], character[9:2], bg_colour[13:10], fg_colour[17:14], cell_index[28:18]
    input  logic [tccs_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // column[6:0], row[11:7], cursor_location[22:12], cell_data[38:23]
    input  logic [tccs_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_scrolls
);

    import tccs_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [DATA_W-1:0] cell_word;
        logic [LOC_W-1:0]  location;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] column;
    } t_cursor_report;

    logic [DATA_W-1:0] screen_model [0:CELLS-1];
    int unsigned       col_now;
    int unsigned       row_now;
    t_cursor_report    reports_due [$];
    t_cursor_report    want;
    t_cursor_report    got;
    int                fail_total = 0;
    int                checked_total = 0;
    int                scroll_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_scrolls    = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("%0t ns: mismatch on result %0d: %s", $time, checked_total, msg);
    endtask

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
    endtask

    // Applies one command word to the model and queues the cursor report it should give.
    task automatic predict_cursor_report(input logic [S_TDATA_W-1:0] w);
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [7:0]         attr;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  data;
        int                 pos;
        t_cursor_report     rep;
        op   = t_op'(w[1:0]);
        ch   = w[9:2];
        attr = {w[13:10], w[17:14]};
        idx  = w[28:18];
        data = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_BS) begin
                    if (col_now != 0)
                        col_now--;
                end else if (ch == CH_TAB) begin
                    col_now = col_now + TAB_WIDTH - (col_now % TAB_WIDTH);
                end else if (ch == CH_CR) begin
                    col_now = 0;
                end else if (ch == CH_LF) begin
                    col_now = 0;
                    row_now++;
                end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                    pos = row_now * COLUMNS + col_now;
                    if (pos < CELLS)
                        screen_model[pos] = {attr, ch};
                    col_now++;
                end
                if (col_now >= COLUMNS) begin
                    col_now = 0;
                    row_now++;
                end
                if (row_now >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        screen_model[i] = BLANK_CELL;
                    row_now = ROWS - 1;
                    scroll_total++;
                end
            end
            OP_CLEAR: begin
                blank_screen();
                col_now = 0;
                row_now = 0;
            end
            OP_READ: begin
                if (idx < CELLS)
                    data = screen_model[idx];
            end
            default: begin
            end
        endcase
        pos          = row_now * COLUMNS + col_now;
        rep.column   = col_now[OCOL_W-1:0];
        rep.row      = row_now[OROW_W-1:0];
        rep.location = pos[LOC_W-1:0];
        rep.cell_word = data;
        reports_due.push_back(rep);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_screen();
            col_now = 0;
            row_now = 0;
            reports_due.delete();
        end else begin
            // Results are compared before the new command is queued, so a word
            // that comes too early cannot match an expectation made this edge.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[OCOL_W+OROW_W+LOC_W+DATA_W-1:0];
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("word 0x%0h with no command waiting", i_m_tdata));
                end else begin
                    want = reports_due.pop_front();
                    if (got.column !== want.column)
                        report_mismatch($sformatf("column %0d, expected %0d",
                                                  got.column, want.column));
                    if (got.row !== want.row)
                        report_mismatch($sformatf("row %0d, expected %0d",
                                                  got.row, want.row));
                    if (got.location !== want.location)
                        report_mismatch($sformatf("cursor_location %0d, expected %0d",
                                                  got.location, want.location));
                    if (got.cell_word !== want.cell_word)
                        report_mismatch($sformatf("cell_data 0x%04h, expected 0x%04h",
                                                  got.cell_word, want.cell_word));
                end
                checked_total++;
            end
            if (i_s_tvalid && i_s_tready)
                predict_cursor_report(i_s_tdata);
        end
        o_fail_count <= fail_total;
        o_pending    <= reports_due.size();
        o_checked    <= checked_total;
        o_scrolls    <= scroll_total;
    end

endmodule

// File: sim/text_console_cursor_scroll_tb.sv
// Testbench top for the text console engine: clock, reset, command stimulus with
// random idling on both channels, and the verdict. Depends on tccs_pkg, the engine
// and text_console_cursor_scroll_chk.
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;

    import tccs_pkg::*;

    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int N_RANDOM      = 1700;
    localparam int QUIET_TAIL    = 200;
    localparam int LONG_STALL    = 400;
    localparam int MAX_GAP       = 6;
    localparam int TAIL_CYCLES   = 16;
    // Slowest command is a put that scrolls: a read and a write per copied cell plus the blank row.
    localparam int SCROLL_CYCLES = 2 * (ROWS - 1) * COLUMNS + COLUMNS + 8;
    localparam int LIMIT_CYCLES  = 4 * ((N_RANDOM * 3 / 2) * (SCROLL_CYCLES + 2 * MAX_GAP)
                                        + ROWS * COLUMNS + LONG_STALL);

    typedef enum int {
        BURST_LINE,
        BURST_WRAP,
        BURST_READS,
        BURST_TABS,
        BURST_FEEDS,
        BURST_NOISE,
        BURST_CLEAR
    } burst_t;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   scrolls;

    bit                   tx_gaps   = 1'b1;
    bit                   rx_gaps   = 1'b1;
    bit                   stall_req = 1'b0;
    int unsigned          cycles    = 0;
    int                   items_done   = 0;
    int                   ignored_sent = 0;
    int                   puts_sent    = 0;
    int                   reads_sent   = 0;
    int                   clears_sent  = 0;

    always #1 i_clk = ~i_clk;

    text_console_cursor_scroll dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    text_console_cursor_scroll_chk cursor_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random ready bursts, and one long hold-off when asked for.
    initial begin : rx_side
        bit stall_served;
        stall_served = 1'b0;
        forever begin
            if (stall_req && !stall_served) begin
                stall_served = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_cmd(input t_op op, input logic [7:0] ch,
                                                      input logic [3:0] bg, input logic [3:0] fg,
                                                      input logic [10:0] idx);
        return {3'b000, idx, fg, bg, ch, op};
    endfunction

    function automatic logic [S_TDATA_W-1:0] put_word(input logic [7:0] ch);
        return pack_cmd(OP_PUT, ch, 4'($urandom), 4'($urandom), 11'($urandom));
    endfunction

    function automatic logic [S_TDATA_W-1:0] read_word(input logic [10:0] idx);
        return pack_cmd(OP_READ, 8'($urandom), 4'($urandom), 4'($urandom), idx);
    endfunction

    // A byte the engine ignores: a control code with no meaning, or one with the top bit set.
    function automatic logic [7:0] rand_ignored();
        logic [7:0] b;
        if ($urandom_range(0, 1)) begin
            b = 8'($urandom_range(128, 255));
        end else begin
            b = 8'($urandom_range(0, 31));
            if (b == CH_BS || b == CH_TAB || b == CH_LF || b == CH_CR)
                b = 8'h1B;
        end
        return b;
    endfunction

    task automatic send_cmd(input logic [S_TDATA_W-1:0] w);
        logic [7:0] ch;
        ch = w[9:2];
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        case (t_op'(w[1:0]))
            OP_PUT: begin
                if (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF
                    || (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI)) begin
                    items_done++;
                    puts_sent++;
                end else begin
                    ignored_sent++;
                end
            end
            OP_CLEAR: begin
                items_done++;
                clears_sent++;
            end
            OP_READ: begin
                items_done++;
                reads_sent++;
            end
            default: ignored_sent++;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_burst(input burst_t kind);
        int n;
        int r;
        case (kind)
            BURST_LINE: begin
                n = $urandom_range(1, 30);
                repeat (n) begin
                    r = $urandom_range(0, 29);
                    if (r == 0)
                        send_cmd(put_word(CH_BS));
                    else if (r == 1)
                        send_cmd(put_word(CH_TAB));
                    else if (r == 2)
                        send_cmd(put_word(rand_ignored()));
                    else
                        send_cmd(put_word(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI))));
                end
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    if (r >= 5)
                        send_cmd(put_word(CH_CR));
                    send_cmd(put_word(CH_LF));
                end else if (r == 7) begin
                    send_cmd(put_word(CH_CR));
                end
            end
            BURST_WRAP: begin
                n = $urandom_range(60, 100);
                repeat (n) send_cmd(put_word(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI))));
            end
            BURST_READS: begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    r = $urandom_range(0, 3);
                    // After scrolling, the written text sits near the bottom rows.
                    if (r < 2)
                        send_cmd(read_word(11'($urandom_range((ROWS - 3) * COLUMNS,
                                                              ROWS * COLUMNS - 1))));
                    else if (r == 2)
                        send_cmd(read_word(11'($urandom_range(0, ROWS * COLUMNS - 1))));
                    else
                        send_cmd(read_word(11'($urandom)));
                end
            end
            BURST_TABS: begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        send_cmd(put_word(CH_BS));
                    else if (r == 1)
                        send_cmd(put_word(CH_CR));
                    else if (r == 2)
                        send_cmd(put_word(rand_ignored()));
                    else
                        send_cmd(put_word(CH_TAB));
                end
            end
            BURST_FEEDS: begin
                n = $urandom_range(5, 25);
                repeat (n) send_cmd(put_word(CH_LF));
            end
            BURST_NOISE: begin
                n = $urandom_range(1, 5);
                repeat (n) send_cmd({3'b000, 29'($urandom)});
            end
            default: send_cmd(pack_cmd(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                                       11'($urandom)));
        endcase
    endtask

    initial begin : stimulus
        int     r;
        bit     paused;
        burst_t kind;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: blank read, colour extremes, cursor controls, ignored bytes,
        // the unused opcode, reads at and past the end of the store, and clear.
        send_cmd(read_word(11'd0));
        send_cmd(pack_cmd(OP_PUT, 8'h41, 4'hF, 4'hF, 11'h000));
        send_cmd(pack_cmd(OP_PUT, CH_PRINT_HI, 4'h0, 4'h0, 11'h7FF));
        send_cmd(pack_cmd(OP_PUT, CH_PRINT_LO, 4'hA, 4'h5, 11'h000));
        send_cmd(read_word(11'd0));
        send_cmd(read_word(11'd2));
        send_cmd(put_word(CH_BS));
        send_cmd(put_word(CH_TAB));
        send_cmd(put_word(CH_BS));
        send_cmd(put_word(CH_CR));
        send_cmd(put_word(CH_BS));
        send_cmd(put_word(CH_LF));
        send_cmd(put_word(8'h00));
        send_cmd(put_word(8'h1F));
        send_cmd(put_word(8'h80));
        send_cmd(put_word(8'hFF));
        send_cmd(pack_cmd(OP_NOP, 8'hFF, 4'hF, 4'hF, 11'h7FF));
        send_cmd(read_word(11'(ROWS * COLUMNS - 1)));
        send_cmd(read_word(11'(ROWS * COLUMNS)));
        send_cmd(read_word(11'h7FF));
        send_cmd(pack_cmd(OP_CLEAR, 8'hFF, 4'hF, 4'hF, 11'h7FF));
        send_cmd(read_word(11'd0));
        send_cmd(put_word(CH_TAB));
        s_tvalid <= 1'b0;
        wait_drained();

        items_done = 0;
        // Start with enough line feeds to push the cursor off the last row.
        send_cmd(put_word(8'h48));
        repeat (ROWS + 5) send_cmd(put_word(CH_LF));
        while (items_done < N_RANDOM) begin
            if (!paused && items_done > N_RANDOM / 3) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end
            if (items_done > N_RANDOM / 2)
                stall_req = 1'b1;
            if (items_done >= N_RANDOM - QUIET_TAIL) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = BURST_LINE;
            else if (r < 55)
                kind = BURST_WRAP;
            else if (r < 75)
                kind = BURST_READS;
            else if (r < 85)
                kind = BURST_TABS;
            else if (r < 90)
                kind = BURST_FEEDS;
            else if (r < 95)
                kind = BURST_NOISE;
            else if (r < 97)
                kind = BURST_CLEAR;
            else
                kind = BURST_READS;
            run_burst(kind);
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d puts, %0d reads and %0d clears, plus %0d ignored words.",
                 puts_sent, reads_sent, clears_sent, ignored_sent);
        $display("Compared %0d cursor reports across %0d screen scrolls, %0d failures.",
                 checked, scrolls, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_useq.sv
hw/rtl/tccs_dpath.sv
hw/rtl/text_console_cursor_scroll.sv
sim/text_console_cursor_scroll_chk.sv
sim/text_console_cursor_scroll_tb.sv
